// File: rtl/core/mwalu_pkg.sv
package mwalu_pkg;

  localparam int LIMB_W        = 32;
  localparam int XLEN          = 64;
  localparam int DEFAULT_LIMBS = 2;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd1,
    FN_NEG = 3'd2,
    FN_NOT = 3'd3,
    FN_MUL = 3'd4,
    FN_DIV = 3'd5,
    FN_CMP = 3'd6
  } func_t;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // Everything but the quotient, carried alongside the divider.
  typedef struct packed {
    logic [2:0]      fn;
    logic [XLEN-1:0] res;
    logic [1:0]      ord;
    logic            dz;
    logic            qneg;
  } side_t;

endpackage

// File: rtl/core/mwalu_div.sv
module mwalu_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         out_valid,
  output logic [W-1:0] quotient
);

  // One quotient bit per stage, restoring.
  logic         v   [W];
  logic [W-1:0] rem [W];
  logic [W-1:0] q   [W];
  logic [W-1:0] d   [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic         v_in;
    logic [W-1:0] rem_in;
    logic [W-1:0] q_in;
    logic [W-1:0] d_in;
    logic [W:0]   shifted;
    logic [W:0]   trial;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign q_in   = dividend;
      assign d_in   = divisor;
    end else begin : g_next
      assign v_in   = v[k-1];
      assign rem_in = rem[k-1];
      assign q_in   = q[k-1];
      assign d_in   = d[k-1];
    end

    assign shifted = {rem_in, q_in[W-1]};
    assign trial   = shifted - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else begin
        v[k] <= v_in;
      end
      d[k] <= d_in;
      if (!trial[W]) begin
        rem[k] <= trial[W-1:0];
        q[k]   <= {q_in[W-2:0], 1'b1};
      end else begin
        rem[k] <= shifted[W-1:0];
        q[k]   <= {q_in[W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = v[W-1];
  assign quotient  = q[W-1];

endmodule

// File: rtl/core/multiword_signed_integer_alu_top.sv
// Signed two's complement ALU over LIMBS 32-bit limbs (64 bits by default):
// add, sub, negate, not, multiply (low bits), divide (truncated toward zero)
// and signed compare. Pulse start with func/operand_a/operand_b; busy is
// always low, so a beat may be issued on every clock. Each beat returns one
// result beat, with done high for one cycle, after the operand capture
// register, the stage B register, the W divider stages (W = 32 bits per
// effective limb, one quotient bit per pipeline stage) and the output
// register; all operations take this path, so results leave in issue order.
// The receiver cannot hold results off: capture them on the cycle done is
// high. Operand bits above W are ignored and results are sign-extended to
// 64 bits. Divide by zero returns zero with div_by_zero set; the most
// negative value over minus one wraps to itself. order is 0/1/2 for a
// less/equal/greater on compare and 0 otherwise; result is 0 on compare and
// for function code 7. LIMBS of 2 or more acts as 2, anything less as 1.
module multiword_signed_integer_alu_top #(
  parameter int LIMBS = mwalu_pkg::DEFAULT_LIMBS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  output logic        done,
  output logic [63:0] result,
  output logic [1:0]  order,
  output logic        div_by_zero
);

  localparam int NL = (LIMBS >= 2) ? 2 : 1;
  localparam int LW = mwalu_pkg::LIMB_W;
  localparam int W  = LW * NL;
  localparam int XL = mwalu_pkg::XLEN;

  function automatic logic [XL-1:0] sx(input logic [W-1:0] x);
    logic signed [W-1:0] t;
    t = x;
    return XL'(t);
  endfunction

  // Fully pipelined: never stalls.
  assign busy = 1'b0;

  // Stage A: operand capture, truncated to W.
  logic         va;
  logic [2:0]   fa;
  logic [W-1:0] a_r;
  logic [W-1:0] b_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= start & ~busy;
    end
    fa  <= func;
    a_r <= operand_a[W-1:0];
    b_r <= operand_b[W-1:0];
  end

  // Stage B: simple ops, compare, magnitudes, limb partial products.
  mwalu_pkg::side_t side_b_next;
  mwalu_pkg::side_t side_b;
  logic [W-1:0]     ua_next;
  logic [W-1:0]     ub_next;
  logic [W-1:0]     ua;
  logic [W-1:0]     ub;
  logic             vb;
  logic [XL-1:0]    pp [NL][NL];

  always_comb begin
    ua_next = a_r[W-1] ? W'(-a_r) : a_r;
    ub_next = b_r[W-1] ? W'(-b_r) : b_r;
    side_b_next      = '0;
    side_b_next.fn   = fa;
    side_b_next.qneg = a_r[W-1] ^ b_r[W-1];
    case (fa)
      mwalu_pkg::FN_ADD: side_b_next.res = sx(W'(a_r + b_r));
      mwalu_pkg::FN_SUB: side_b_next.res = sx(W'(a_r - b_r));
      mwalu_pkg::FN_NEG: side_b_next.res = sx(W'(-a_r));
      mwalu_pkg::FN_NOT: side_b_next.res = sx(~a_r);
      mwalu_pkg::FN_DIV: side_b_next.dz  = (b_r == '0);
      mwalu_pkg::FN_CMP: begin
        if ($signed(a_r) < $signed(b_r)) begin
          side_b_next.ord = mwalu_pkg::ORD_LT;
        end else if (a_r == b_r) begin
          side_b_next.ord = mwalu_pkg::ORD_EQ;
        end else begin
          side_b_next.ord = mwalu_pkg::ORD_GT;
        end
      end
      default: side_b_next.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    side_b <= side_b_next;
    ua     <= ua_next;
    ub     <= ub_next;
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        if (i + j < NL) begin
          pp[i][j] <= XL'(a_r[i*LW +: LW]) * XL'(b_r[j*LW +: LW]);
        end else begin
          pp[i][j] <= '0;
        end
      end
    end
  end

  // Stage C: fold partial products (only terms landing below W count).
  mwalu_pkg::side_t side_c_next;
  logic [W-1:0]     mul_sum;

  always_comb begin
    mul_sum = '0;
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        if (i + j < NL) begin
          mul_sum = W'(mul_sum + W'(pp[i][j] << (LW * (i + j))));
        end
      end
    end
    side_c_next = side_b;
    if (side_b.fn == mwalu_pkg::FN_MUL) begin
      side_c_next.res = sx(mul_sum);
    end
  end

  // Side line runs beside the W divider stages.
  mwalu_pkg::side_t sd [W];

  always_ff @(posedge clk) begin
    sd[0] <= side_c_next;
    for (int k = 1; k < W; k++) begin
      sd[k] <= sd[k-1];
    end
  end

  logic         dv;
  logic [W-1:0] quo;

  mwalu_div #(
    .W(W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vb),
    .dividend (ua),
    .divisor  (ub),
    .out_valid(dv),
    .quotient (quo)
  );

  // Final stage: quotient sign, select, output register.
  mwalu_pkg::side_t fin;
  logic [XL-1:0]    result_next;

  always_comb begin
    fin = sd[W-1];
    result_next = fin.res;
    if (fin.fn == mwalu_pkg::FN_DIV && !fin.dz) begin
      result_next = sx(fin.qneg ? W'(-quo) : quo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv;
    end
    result      <= result_next;
    order       <= fin.ord;
    div_by_zero <= fin.dz;
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

// Checks the multiword ALU top at its default width (two limbs, 64 bits).
// Beats go in through start/busy; each beat's outcome is computed here and
// queued, and every done pulse is compared field by field with the oldest one.
module testbench;

  localparam int LATENCY    = 66;
  localparam int STALL_MAX  = 5000;
  localparam int N_RANDOM   = 500;

  typedef struct {
    logic [2:0]  fn;
    logic [63:0] a;
    logic [63:0] b;
    logic        drain;   // hold off until all outcomes have come back
  } alu_beat_t;

  typedef struct {
    logic [63:0] res;
    logic [1:0]  ord;
    logic        dz;
  } alu_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  func = '0;
  logic [63:0] operand_a = '0;
  logic [63:0] operand_b = '0;
  logic        done;
  logic [63:0] result;
  logic [1:0]  order;
  logic        div_by_zero;

  alu_beat_t pending_q[$];
  alu_out_t  outcome_q[$];
  int        errors = 0;
  int        idle_cycles = 0;
  bit        stim_done = 1'b0;
  int        gap = 0;

  multiword_signed_integer_alu_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .operand_a(operand_a), .operand_b(operand_b), .done(done),
    .result(result), .order(order), .div_by_zero(div_by_zero)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Outcome of one ALU beat at 64-bit width.
  function automatic alu_out_t alu_outcome(logic [2:0] fn, logic [63:0] a, logic [63:0] b);
    alu_out_t o;
    logic [63:0] ua, ub, q;
    o.res = '0;
    o.ord = mwalu_pkg::ORD_LT;
    o.dz  = 1'b0;
    case (fn)
      mwalu_pkg::FN_ADD: o.res = a + b;
      mwalu_pkg::FN_SUB: o.res = a - b;
      mwalu_pkg::FN_NEG: o.res = -a;
      mwalu_pkg::FN_NOT: o.res = ~a;
      mwalu_pkg::FN_MUL: o.res = a * b;
      mwalu_pkg::FN_DIV: begin
        if (b == '0) begin
          o.dz = 1'b1;
        end else begin
          ua = a[63] ? -a : a;
          ub = b[63] ? -b : b;
          q = ua / ub;
          o.res = (a[63] != b[63]) ? -q : q;
        end
      end
      mwalu_pkg::FN_CMP: begin
        if ($signed(a) < $signed(b)) o.ord = mwalu_pkg::ORD_LT;
        else if (a == b) o.ord = mwalu_pkg::ORD_EQ;
        else o.ord = mwalu_pkg::ORD_GT;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = 64'h8000_0000_0000_0000;
      1: v = 64'h7fff_ffff_ffff_ffff;
      2: v = '1;
      3: v = '0;
      4: v = 64'($urandom_range(0, 20));
      5: v = -64'($urandom_range(0, 20));
      6: v = {{32{v[31]}}, v[31:0]};
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_beat(logic [2:0] fn, logic [63:0] a, logic [63:0] b, bit drain = 0);
    alu_beat_t t;
    t.fn = fn; t.a = a; t.b = b; t.drain = drain;
    pending_q.push_back(t);
  endtask

  // Driver: changes inputs on the falling edge, random gaps between beats.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // beat not yet taken, hold it
    end else if (gap > 0) begin
      gap <= gap - 1;
      start <= 1'b0;
    end else if (pending_q.size() > 0 &&
                 !(pending_q[0].drain && outcome_q.size() > 0)) begin
      alu_beat_t t;
      t = pending_q.pop_front();
      start <= 1'b1;
      func <= t.fn;
      operand_a <= t.a;
      operand_b <= t.b;
      outcome_q.push_back(alu_outcome(t.fn, t.a, t.b));
      case ($urandom_range(0, 9))
        0, 1, 2: gap <= $urandom_range(1, 3);
        3:       gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : 0;
        default: gap <= 0;
      endcase
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: sample results at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: result=%h order=%0d dz=%0b",
                   $realtime, result, order, div_by_zero);
          errors <= errors + 1;
        end else begin
          alu_out_t e;
          e = outcome_q.pop_front();
          if (result !== e.res || order !== e.ord || div_by_zero !== e.dz) begin
            $display("%0t: mismatch expected result=%h order=%0d dz=%0b, got %h %0d %0b",
                     $realtime, e.res, e.ord, e.dz, result, order, div_by_zero);
            errors <= errors + 1;
          end
        end
      end
      if (idle_cycles > STALL_MAX) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] mn, mx;
    mn = 64'h8000_0000_0000_0000;
    mx = 64'h7fff_ffff_ffff_ffff;
    // Directed: field extremes, each function, the corner cases.
    add_beat(mwalu_pkg::FN_ADD, mx, 64'd1);
    add_beat(mwalu_pkg::FN_ADD, '1, '1);
    add_beat(mwalu_pkg::FN_SUB, mn, 64'd1);
    add_beat(mwalu_pkg::FN_SUB, '0, mn);
    add_beat(mwalu_pkg::FN_NEG, mn, '1);            // wraps to itself
    add_beat(mwalu_pkg::FN_NEG, 64'd5, '0);
    add_beat(mwalu_pkg::FN_NOT, '0, mx);
    add_beat(mwalu_pkg::FN_NOT, 64'h0123_4567_89ab_cdef, '0);
    add_beat(mwalu_pkg::FN_MUL, mx, mx);
    add_beat(mwalu_pkg::FN_MUL, mn, '1);
    add_beat(mwalu_pkg::FN_DIV, 64'd100, '0);       // divide by zero
    add_beat(mwalu_pkg::FN_DIV, mn, '1);            // most-negative over minus one
    add_beat(mwalu_pkg::FN_DIV, -64'sd7, 64'd2);
    add_beat(mwalu_pkg::FN_DIV, 64'd7, -64'sd2);
    add_beat(mwalu_pkg::FN_DIV, mx, mn);
    add_beat(mwalu_pkg::FN_CMP, mn, mx);
    add_beat(mwalu_pkg::FN_CMP, mx, mn);
    add_beat(mwalu_pkg::FN_CMP, '1, '1);
    add_beat(3'd7, '1, '1);                         // unused code
    add_beat(mwalu_pkg::FN_ADD, '0, '0, 1);         // pause until the pipe drains
    for (int i = 0; i < N_RANDOM; i++)
      add_beat(3'($urandom_range(0, 7)), rand_operand(), rand_operand(), (i % 150) == 149);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() > 0 || outcome_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
